// ----- src/hs_pkg.sv -----
// shared constants and types for the heap sorter
`default_nettype none

package hs_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = CNT_W + 1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic strobe;
        logic final_res;
        logic overflow;
    } res_t;

endpackage

`default_nettype wire

// ----- src/hs_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/hs_seq.sv -----
// load, heap build, extraction and output sequencer
`default_nettype none

module hs_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic signed [hs_pkg::DATA_W-1:0] value,
    input  wire logic                         last,
    input  wire logic [hs_pkg::DATA_W-1:0]    rdata,
    output logic                              busy,
    output hs_pkg::mem_req_t                  mem,
    output hs_pkg::res_t                      res
);

    import hs_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_BUILD   = 11'b000_0000_0010,
        ST_FETCH   = 11'b000_0000_0100,
        ST_RD_L    = 11'b000_0000_1000,
        ST_RD_R    = 11'b000_0001_0000,
        ST_CMP     = 11'b000_0010_0000,
        ST_EXTRACT = 11'b000_0100_0000,
        ST_EX_RD   = 11'b000_1000_0000,
        ST_EX_WR   = 11'b001_0000_0000,
        ST_OUT     = 11'b010_0000_0000,
        ST_DRAIN   = 11'b100_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [DATA_W-1:0] lval_reg, lval_next;
    logic              build_reg, build_next;
    logic              pend_reg, pend_next;
    logic              pend_last_reg, pend_last_next;

    logic [CHILD_W-1:0] lc;
    logic [CHILD_W-1:0] rc;
    logic [CHILD_W-1:0] len_ext;
    logic               lc_in;
    logic               rc_in;
    logic               use_r;
    logic [DATA_W-1:0]  bval;
    logic [CHILD_W-1:0] bidx;
    logic [CNT_W-1:0]   k_dec;
    logic [CNT_W-1:0]   fill_dec;
    logic [CNT_W-1:0]   fill_inc;
    logic               has_room;
    state_t             done_state;

    assign lc       = (CHILD_W'(node_reg) << 1) | CHILD_W'(1);
    assign rc       = lc + CHILD_W'(1);
    assign len_ext  = CHILD_W'(len_reg);
    assign lc_in    = lc < len_ext;
    assign rc_in    = rc < len_ext;
    assign use_r    = rc_in && ($signed(rdata) > $signed(lval_reg));
    assign bval     = use_r ? rdata : lval_reg;
    assign bidx     = use_r ? rc : lc;
    assign k_dec    = k_reg - CNT_W'(1);
    assign fill_dec = fill_reg - CNT_W'(1);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign has_room = fill_reg < CNT_W'(CAPACITY);
    assign done_state = build_reg ? ST_BUILD : ST_EXTRACT;

    assign busy = (state_reg != ST_IDLE);
    assign res.strobe    = pend_reg;
    assign res.final_res = pend_last_reg;
    assign res.overflow  = ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        lval_next      = lval_reg;
        build_next     = build_reg;
        pend_next      = 1'b0;
        pend_last_next = 1'b0;
        mem.we         = 1'b0;
        mem.waddr      = node_reg;
        mem.wdata      = cur_reg;
        mem.raddr      = node_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (has_room)
                    begin
                        mem.we    = 1'b1;
                        mem.waddr = fill_reg[ADDR_W-1:0];
                        mem.wdata = value;
                        fill_next = fill_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        len_next   = has_room ? fill_inc : fill_reg;
                        k_next     = (has_room ? fill_inc : fill_reg) >> 1;
                        build_next = 1'b1;
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_BUILD:
            begin
                if (k_reg == '0)
                begin
                    k_next     = fill_reg;
                    build_next = 1'b0;
                    state_next = ST_EXTRACT;
                end
                else
                begin
                    node_next  = k_dec[ADDR_W-1:0];
                    mem.raddr  = k_dec[ADDR_W-1:0];
                    k_next     = k_dec;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cur_next   = rdata;
                state_next = ST_RD_L;
            end
            ST_RD_L:
            begin
                if (lc_in)
                begin
                    mem.raddr  = lc[ADDR_W-1:0];
                    state_next = ST_RD_R;
                end
                else
                begin
                    mem.we     = 1'b1;
                    state_next = done_state;
                end
            end
            ST_RD_R:
            begin
                lval_next  = rdata;
                mem.raddr  = rc[ADDR_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                mem.we = 1'b1;
                if ($signed(bval) > $signed(cur_reg))
                begin
                    mem.wdata  = bval;
                    node_next  = bidx[ADDR_W-1:0];
                    state_next = ST_RD_L;
                end
                else
                begin
                    state_next = done_state;
                end
            end
            ST_EXTRACT:
            begin
                if (k_reg <= CNT_W'(1))
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    mem.raddr  = '0;
                    state_next = ST_EX_RD;
                end
            end
            ST_EX_RD:
            begin
                lval_next  = rdata;
                mem.raddr  = k_dec[ADDR_W-1:0];
                state_next = ST_EX_WR;
            end
            ST_EX_WR:
            begin
                cur_next   = rdata;
                mem.we     = 1'b1;
                mem.waddr  = k_dec[ADDR_W-1:0];
                mem.wdata  = lval_reg;
                len_next   = k_dec;
                k_next     = k_dec;
                node_next  = '0;
                state_next = ST_RD_L;
            end
            ST_OUT:
            begin
                mem.raddr      = idx_reg[ADDR_W-1:0];
                pend_next      = 1'b1;
                pend_last_next = (idx_reg == fill_dec);
                idx_next       = idx_reg + CNT_W'(1);
                if (idx_reg == fill_dec)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                fill_next  = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            build_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            build_reg     <= build_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        lval_reg <= lval_next;
    end

endmodule

`default_nettype wire

// ----- src/heap_sorter.sv -----
// heap sorter top level: element store and sequencer
//
//  channel   handshake             payload
//  input     start, busy           value, last
//  result    strobe (no stall)     sorted_value, final_res, overflow
//
//  an item is taken whenever start is high while busy is low; an item with last starts the sort
//  each sift level passes through states ST_RD_L, ST_RD_R, ST_CMP on the single store read port;
//  a full batch holds up to 64 items and runs through load, heap build, extraction and output
//  results then stream out one per cycle, busy falls the cycle after the final one
//  reset clears the fill count and overflow flag; the store itself is not cleared
//  the receiver cannot stall: each result shows for exactly one cycle
`default_nettype none

module heap_sorter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic signed [hs_pkg::DATA_W-1:0] value,
    input  wire logic                             last,
    output logic                                  strobe,
    output logic signed [hs_pkg::DATA_W-1:0]      sorted_value,
    output logic                                  final_res,
    output logic                                  overflow
);

    import hs_pkg::*;

    mem_req_t          mem;
    res_t              res;
    logic [DATA_W-1:0] rdata;

    hs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value),
        .last  (last),
        .rdata (rdata),
        .busy  (busy),
        .mem   (mem),
        .res   (res)
    );

    hs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    assign strobe       = res.strobe;
    assign final_res    = res.final_res;
    assign overflow     = res.overflow;
    assign sorted_value = $signed(rdata);

endmodule

`default_nettype wire
